>>> rtl/core/sstq_pkg.sv
// ---------------------------------------------------------------------------
// sstq_pkg
// Shared types and constants of the sorted sleep timer queue.
// ---------------------------------------------------------------------------
package sstq_pkg;

  localparam int unsigned QUEUE_DEPTH    = 16;
  localparam int unsigned THREAD_ID_BITS = 8;
  localparam int unsigned TID_W          = 8;
  localparam int unsigned TIME_W         = 31;
  localparam int unsigned DELAY_W        = 32;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_WOKEN    = 2'd0,
    KIND_TICK     = 2'd1,
    KIND_ACCEPTED = 2'd2,
    KIND_REJECTED = 2'd3
  } kind_t;

  typedef enum logic {
    FUNC_SLEEP = 1'b0,
    FUNC_TICK  = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_SLP_DONE,
    ST_TK_RD,
    ST_TK_CMP,
    ST_TK_DONE
  } state_t;

endpackage

>>> rtl/core/sstq_in_if.sv
// ---------------------------------------------------------------------------
// sstq_in_if
// Request channel: sleep requests and timer ticks.
// ---------------------------------------------------------------------------
interface sstq_in_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [sstq_pkg::TID_W-1:0]        thread_id;
  logic signed [sstq_pkg::DELAY_W-1:0] delay;
  logic [sstq_pkg::TIME_W-1:0]       now_time;
  logic                              cpu_idle;

  modport source (output valid, func, thread_id, delay, now_time, cpu_idle,
                  input ready);
  modport sink   (input valid, func, thread_id, delay, now_time, cpu_idle,
                  output ready);
endinterface

>>> rtl/core/sstq_out_if.sv
// ---------------------------------------------------------------------------
// sstq_out_if
// Result channel: woken threads and completion beats.
// ---------------------------------------------------------------------------
interface sstq_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [sstq_pkg::TID_W-1:0] woken_thread;
  logic                       yield_request;
  logic                       last;

  modport source (output valid, kind, woken_thread, yield_request, last,
                  input ready);
  modport sink   (input valid, kind, woken_thread, yield_request, last,
                  output ready);
endinterface

>>> rtl/core/sstq_ram.sv
// ---------------------------------------------------------------------------
// sstq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sstq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/sorted_sleep_timer_queue_top.sv
// ---------------------------------------------------------------------------
// sorted_sleep_timer_queue_top
// Sleep queue kept sorted by wake time in a circular buffer in one RAM.
//
//   channel | dir | beat contents
//   req     | in  | func, thread_id, delay, now_time, cpu_idle
//   rsp     | out | kind, woken_thread, yield_request, last
//
// One item at a time. Sleep: a rejected request goes straight to its result; an
// item for an empty queue is written at once; else entries are examined from
// the tail (one RAM read then a compare; later entries are written one slot
// toward the tail). Tick: each due entry at the head is read, compared and
// released, until the queue is empty or an entry that is not yet due is left.
// Reset (sync, rst) empties the queue; no clearing pass.
// A stalled rsp holds the engine.
// ---------------------------------------------------------------------------
module sorted_sleep_timer_queue_top #(
  parameter int unsigned QUEUE_DEPTH    = sstq_pkg::QUEUE_DEPTH,
  parameter int unsigned THREAD_ID_BITS = sstq_pkg::THREAD_ID_BITS
) (
  input logic        clk,
  input logic        rst,
  sstq_in_if.sink    req,
  sstq_out_if.source rsp
);

  localparam int unsigned IW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW  = sstq_pkg::TIME_W;
  localparam int unsigned XW  = (THREAD_ID_BITS > sstq_pkg::TID_W) ?
                                THREAD_ID_BITS : sstq_pkg::TID_W;
  localparam int unsigned EW  = THREAD_ID_BITS + TW;

  sstq_pkg::state_t state, state_next;

  logic [IW-1:0]             head;
  logic [CW-1:0]             count;
  logic [CW-1:0]             pos;
  logic [THREAD_ID_BITS-1:0] new_tid;
  logic [TW-1:0]             new_wake;
  logic [TW-1:0]             now_r;
  logic                      idle_r;
  logic                      reject;

  // RAM ports
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [THREAD_ID_BITS-1:0] rd_tid;
  logic [TW-1:0]             rd_wake;

  // control strobes
  logic accept, pos_dec, ins_done, pop, load_out, emit_ok;
  sstq_pkg::kind_t           out_kind;
  logic [THREAD_ID_BITS-1:0] out_tid;
  logic                      out_yield, out_last;

  // request decode
  logic [XW-1:0]             tid_wide;
  logic [TW:0]               wake_sum;
  logic [TW-1:0]             wake_sat;
  logic                      bad_req;

  // Circular buffer slot for a logical offset from head.
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h,
                                         input logic [CW-1:0] ofs);
    logic [IW:0] s;
    s = {1'b0, h} + (IW+1)'(ofs);
    if (s >= (IW+1)'(QUEUE_DEPTH)) begin
      s = s - (IW+1)'(QUEUE_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  sstq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_tid  = rdata[EW-1:TW];
  assign rd_wake = rdata[TW-1:0];

  // Wake time, saturating; delay is known positive when it is used.
  always_comb begin
    tid_wide = XW'(req.thread_id);
    wake_sum = {1'b0, req.now_time} + {1'b0, req.delay[TW-1:0]};
    wake_sat = wake_sum[TW] ? sstq_pkg::TIME_MAX : wake_sum[TW-1:0];
    bad_req  = (req.delay == '0) || req.delay[sstq_pkg::DELAY_W-1] ||
               (count == CW'(QUEUE_DEPTH));
  end

  assign emit_ok   = !rsp.valid || rsp.ready;
  assign req.ready = (state == sstq_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;

  // Next state and datapath strobes
  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = phys(head, pos);
    wdata      = {new_tid, new_wake};
    raddr      = head;
    pos_dec    = 1'b0;
    ins_done   = 1'b0;
    pop        = 1'b0;
    load_out   = 1'b0;
    out_kind   = sstq_pkg::KIND_TICK;
    out_tid    = '0;
    out_yield  = 1'b0;
    out_last   = 1'b1;
    case (state)
      sstq_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.func == sstq_pkg::FUNC_SLEEP) begin
            if (bad_req) begin
              state_next = sstq_pkg::ST_SLP_DONE;
            end else if (count == '0) begin
              state_next = sstq_pkg::ST_INS_PUT;
            end else begin
              state_next = sstq_pkg::ST_INS_RD;
            end
          end else if (count == '0) begin
            state_next = sstq_pkg::ST_TK_DONE;
          end else begin
            state_next = sstq_pkg::ST_TK_RD;
          end
        end
      end
      sstq_pkg::ST_INS_RD: begin
        raddr      = phys(head, pos - CW'(1));
        state_next = sstq_pkg::ST_INS_CMP;
      end
      sstq_pkg::ST_INS_CMP: begin
        // later wake time moves one slot toward the tail
        if (rd_wake > new_wake) begin
          we         = 1'b1;
          wdata      = rdata;
          pos_dec    = 1'b1;
          state_next = (pos == CW'(1)) ? sstq_pkg::ST_INS_PUT : sstq_pkg::ST_INS_RD;
        end else begin
          state_next = sstq_pkg::ST_INS_PUT;
        end
      end
      sstq_pkg::ST_INS_PUT: begin
        we         = 1'b1;
        ins_done   = 1'b1;
        state_next = sstq_pkg::ST_SLP_DONE;
      end
      sstq_pkg::ST_SLP_DONE: begin
        out_kind = reject ? sstq_pkg::KIND_REJECTED : sstq_pkg::KIND_ACCEPTED;
        if (emit_ok) begin
          load_out   = 1'b1;
          state_next = sstq_pkg::ST_IDLE;
        end
      end
      sstq_pkg::ST_TK_RD: begin
        state_next = sstq_pkg::ST_TK_CMP;
      end
      sstq_pkg::ST_TK_CMP: begin
        // front entry due: release it
        if (rd_wake <= now_r) begin
          out_kind = sstq_pkg::KIND_WOKEN;
          out_tid  = rd_tid;
          out_last = 1'b0;
          if (emit_ok) begin
            load_out   = 1'b1;
            pop        = 1'b1;
            state_next = (count == CW'(1)) ? sstq_pkg::ST_TK_DONE : sstq_pkg::ST_TK_RD;
          end
        end else begin
          state_next = sstq_pkg::ST_TK_DONE;
        end
      end
      sstq_pkg::ST_TK_DONE: begin
        out_kind  = sstq_pkg::KIND_TICK;
        out_yield = !idle_r;
        if (emit_ok) begin
          load_out   = 1'b1;
          state_next = sstq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sstq_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sstq_pkg::ST_IDLE;
      head      <= '0;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ins_done) begin
        count <= count + CW'(1);
      end else if (pop) begin
        count <= count - CW'(1);
        head  <= (head == IW'(QUEUE_DEPTH - 1)) ? '0 : head + IW'(1);
      end
      if (load_out) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      new_tid  <= tid_wide[THREAD_ID_BITS-1:0];
      new_wake <= wake_sat;
      now_r    <= req.now_time;
      idle_r   <= req.cpu_idle;
      reject   <= bad_req;
      pos      <= count;
    end else if (pos_dec) begin
      pos <= pos - CW'(1);
    end
    if (load_out) begin
      rsp.kind          <= out_kind;
      rsp.woken_thread  <= sstq_pkg::TID_W'(XW'(out_tid));
      rsp.yield_request <= out_yield;
      rsp.last          <= out_last;
    end
  end

endmodule

>>> tb/sorted_sleep_timer_queue_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sorted_sleep_timer_queue_top_tb
// Drives sleep requests and timer ticks into the sorted sleep queue and
// checks every result beat against a behavioral model of the queue kept
// here. A directed table covers rejects, saturation, ties and full queue;
// random sleep/tick traffic follows, with bursty input and a stalling sink.
// ---------------------------------------------------------------------------
module sorted_sleep_timer_queue_top_tb;

  typedef struct packed {
    logic                         func;
    logic [sstq_pkg::TID_W-1:0]   thread_id;
    logic [sstq_pkg::DELAY_W-1:0] delay;
    logic [sstq_pkg::TIME_W-1:0]  now_time;
    logic                         cpu_idle;
  } req_beat_t;

  typedef struct packed {
    logic [1:0]                 kind;
    logic [sstq_pkg::TID_W-1:0] woken_thread;
    logic                       yield_request;
    logic                       last;
  } rsp_beat_t;

  typedef struct {
    req_beat_t beat;
    logic      has_exp;
    rsp_beat_t exp;
  } table_row_t;

  localparam int LIMIT_CYCLES = 400000;

  logic clk;
  logic rst;
  sstq_in_if  req ();
  sstq_out_if rsp ();

  sorted_sleep_timer_queue_top dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  // model of the sleep queue
  logic [sstq_pkg::TID_W-1:0]  sleeper_tid  [sstq_pkg::QUEUE_DEPTH];
  logic [sstq_pkg::TIME_W-1:0] sleeper_wake [sstq_pkg::QUEUE_DEPTH];
  int                          sleeper_cnt;
  rsp_beat_t                   pending_rsp [$];
  int                          mismatches;
  int                          cycle_cnt;
  table_row_t                  dir_rows [$];
  logic [31:0]                 time_now;

  function automatic rsp_beat_t mk_rsp(sstq_pkg::kind_t k,
                                       logic [sstq_pkg::TID_W-1:0] t, logic y);
    rsp_beat_t r;
    r.kind = k; r.woken_thread = t; r.yield_request = y;
    r.last = (k != sstq_pkg::KIND_WOKEN);
    return r;
  endfunction

  // apply one request to the model and queue its results
  task automatic predict_queue(req_beat_t b);
    logic [32:0] wake;
    int pos;
    int n;
    if (b.func == sstq_pkg::FUNC_SLEEP) begin
      if (b.delay == 0 || b.delay[31] || sleeper_cnt >= sstq_pkg::QUEUE_DEPTH) begin
        pending_rsp.push_back(mk_rsp(sstq_pkg::KIND_REJECTED, '0, 1'b0));
      end else begin
        wake = {2'b0, b.now_time} + {1'b0, b.delay};
        if (wake > {2'b0, sstq_pkg::TIME_MAX}) wake = {2'b0, sstq_pkg::TIME_MAX};
        pos = sleeper_cnt;
        while (pos > 0 && sleeper_wake[pos-1] > wake[sstq_pkg::TIME_W-1:0]) pos--;
        for (int i = sleeper_cnt; i > pos; i--) begin
          sleeper_tid[i]  = sleeper_tid[i-1];
          sleeper_wake[i] = sleeper_wake[i-1];
        end
        sleeper_tid[pos]  = b.thread_id;
        sleeper_wake[pos] = wake[sstq_pkg::TIME_W-1:0];
        sleeper_cnt++;
        pending_rsp.push_back(mk_rsp(sstq_pkg::KIND_ACCEPTED, '0, 1'b0));
      end
    end else begin
      n = 0;
      while (n < sleeper_cnt && sleeper_wake[n] <= b.now_time) begin
        pending_rsp.push_back(mk_rsp(sstq_pkg::KIND_WOKEN, sleeper_tid[n], 1'b0));
        n++;
      end
      for (int i = n; i < sleeper_cnt; i++) begin
        sleeper_tid[i-n]  = sleeper_tid[i];
        sleeper_wake[i-n] = sleeper_wake[i];
      end
      sleeper_cnt -= n;
      pending_rsp.push_back(mk_rsp(sstq_pkg::KIND_TICK, '0, !b.cpu_idle));
    end
  endtask

  function automatic req_beat_t mk_req(logic f, logic [7:0] t, logic [31:0] d,
                                       logic [30:0] nt, logic idle);
    req_beat_t b;
    b.func = f; b.thread_id = t; b.delay = d; b.now_time = nt; b.cpu_idle = idle;
    return b;
  endfunction

  function automatic table_row_t mk_row(req_beat_t b, logic e, rsp_beat_t x);
    table_row_t r;
    r.beat = b; r.has_exp = e; r.exp = x;
    return r;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // predict, check a typed expectation, then drive one beat until accepted;
  // valid drops only during a gap, so an accepted beat is never resent
  task automatic send_beat(req_beat_t b, logic has_exp, rsp_beat_t exp);
    int base;
    base = pending_rsp.size();
    predict_queue(b);
    if (has_exp && pending_rsp[base] !== exp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row: exp %p model %p", exp, pending_rsp[base]);
    end
    if ($urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.func      <= b.func;
    req.thread_id <= b.thread_id;
    req.delay     <= b.delay;
    req.now_time  <= b.now_time;
    req.cpu_idle  <= b.cpu_idle;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // sink stall pattern: phases of steady ready and random stalls
  initial begin
    int phase;
    rsp.ready <= 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase = (phase + 1) % 64;
      if (phase < 16) rsp.ready <= 1'b1;
      else rsp.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    rsp_beat_t got;
    rsp_beat_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got.kind = rsp.kind; got.woken_thread = rsp.woken_thread;
      got.yield_request = rsp.yield_request; got.last = rsp.last;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %p", got);
      end else begin
        want = pending_rsp.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: exp %p got %p", want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus
  initial begin
    req_beat_t b;
    int sent;
    rst = 1'b1;
    req.valid <= 1'b0; req.func <= 1'b0; req.thread_id <= '0;
    req.delay <= '0; req.now_time <= '0; req.cpu_idle <= 1'b0;
    mismatches = 0; cycle_cnt = 0; sleeper_cnt = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    dir_rows.push_back(mk_row(mk_req(sstq_pkg::FUNC_TICK, 0, 0, 0, 1), 1,
                              mk_rsp(sstq_pkg::KIND_TICK, 0, 0)));
    dir_rows.push_back(mk_row(mk_req(sstq_pkg::FUNC_TICK, 0, 0, 0, 0), 1,
                              mk_rsp(sstq_pkg::KIND_TICK, 0, 1)));
    dir_rows.push_back(mk_row(mk_req(sstq_pkg::FUNC_SLEEP, 8'h11, 0, 5, 0), 1,
                              mk_rsp(sstq_pkg::KIND_REJECTED, 0, 0)));
    dir_rows.push_back(mk_row(mk_req(sstq_pkg::FUNC_SLEEP, 8'h12, 32'h8000_0000, 5, 0), 1,
                              mk_rsp(sstq_pkg::KIND_REJECTED, 0, 0)));
    dir_rows.push_back(mk_row(mk_req(sstq_pkg::FUNC_SLEEP, 8'h13, 32'hFFFF_FFFF, 5, 0), 1,
                              mk_rsp(sstq_pkg::KIND_REJECTED, 0, 0)));
    dir_rows.push_back(mk_row(mk_req(sstq_pkg::FUNC_SLEEP, 8'hFF, 32'h7FFF_FFFF,
                                     31'h7FFF_FFFF, 1), 1,
                              mk_rsp(sstq_pkg::KIND_ACCEPTED, 0, 0)));
    dir_rows.push_back(mk_row(mk_req(sstq_pkg::FUNC_SLEEP, 8'h00, 1, 0, 0), 0,
                              mk_rsp(sstq_pkg::KIND_ACCEPTED, 0, 0)));
    dir_rows.push_back(mk_row(mk_req(sstq_pkg::FUNC_SLEEP, 8'hA5, 10, 0, 0), 0,
                              mk_rsp(sstq_pkg::KIND_ACCEPTED, 0, 0)));
    dir_rows.push_back(mk_row(mk_req(sstq_pkg::FUNC_SLEEP, 8'h5A, 5, 5, 0), 0,
                              mk_rsp(sstq_pkg::KIND_ACCEPTED, 0, 0)));
    dir_rows.push_back(mk_row(mk_req(sstq_pkg::FUNC_SLEEP, 8'h3C, 2, 3, 1), 0,
                              mk_rsp(sstq_pkg::KIND_ACCEPTED, 0, 0)));
    // fill to full with mixed wake times, then one more is rejected
    for (int i = 0; i < 11; i++)
      dir_rows.push_back(mk_row(mk_req(sstq_pkg::FUNC_SLEEP, 8'(i * 17),
                                       32'(1 + (i % 4) * 3), 0, 0),
                                0, mk_rsp(sstq_pkg::KIND_ACCEPTED, 0, 0)));
    dir_rows.push_back(mk_row(mk_req(sstq_pkg::FUNC_SLEEP, 8'h77, 1, 0, 0), 1,
                              mk_rsp(sstq_pkg::KIND_REJECTED, 0, 0)));
    dir_rows.push_back(mk_row(mk_req(sstq_pkg::FUNC_TICK, 0, 0, 31'h7FFF_FFFE, 0), 0,
                              mk_rsp(sstq_pkg::KIND_TICK, 0, 0)));
    dir_rows.push_back(mk_row(mk_req(sstq_pkg::FUNC_TICK, 0, 0, 31'h7FFF_FFFF, 1), 0,
                              mk_rsp(sstq_pkg::KIND_TICK, 0, 0)));

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].beat, dir_rows[i].has_exp, dir_rows[i].exp);
    end

    // random traffic: time advances mostly, sleeps and ticks mixed
    time_now = 0;
    sent = 0;
    while (sent < 300) begin
      if ($urandom_range(0, 15) == 0) time_now = $urandom & 32'h7FFF_FFFF;
      else time_now = time_now + $urandom_range(0, 8);
      if (time_now > 32'h7FFF_FFFF) time_now = 32'h7FFF_FFFF;
      b.func = ($urandom_range(0, 2) == 0);
      b.thread_id = 8'($urandom);
      case ($urandom_range(0, 9))
        0: b.delay = $urandom;
        1: b.delay = -$urandom_range(0, 5);
        2: b.delay = 32'h7FFF_FFFF - $urandom_range(0, 3);
        default: b.delay = $urandom_range(1, 20);
      endcase
      b.now_time = time_now[30:0];
      b.cpu_idle = 1'($urandom_range(0, 1));
      send_beat(b, 1'b0, mk_rsp(sstq_pkg::KIND_TICK, 0, 0));
      sent++;
    end
    req.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
